// ===== hw/rtl/bcpc_pkg.sv =====
// Shared types, constants and the combination table for the button combo
// press classifier. No dependencies; every other file of the block uses it.
`default_nettype none

package bcpc_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned BTN_IDX_W   = 2;
  localparam int unsigned TS_W        = 32;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned HELD_W      = 8;
  localparam int unsigned COMBO_W     = 3;

  localparam logic [HELD_W-1:0]    HELD_SAT  = 8'hFF;
  localparam logic [HELD_W-1:0]    LPS_RESET = 8'd2;
  localparam logic [BTN_IDX_W-1:0] NUM_BTN_IDX = 2'd3;

  typedef enum logic {
    OP_RELEASE = 1'b0,
    OP_PRESS   = 1'b1
  } op_e;

  // Combination number 1..7 (A, B, M, AB, AM, BM, ABM) for a button mask.
  function automatic logic [COMBO_W-1:0] combo_number(input logic [NUM_BUTTONS-1:0] mask);
    logic [COMBO_W-1:0] num;
    case (mask)
      3'b000:  num = 3'd0;
      3'b001:  num = 3'd1;
      3'b010:  num = 3'd2;
      3'b011:  num = 3'd4;
      3'b100:  num = 3'd3;
      3'b101:  num = 3'd5;
      3'b110:  num = 3'd6;
      3'b111:  num = 3'd7;
      default: num = 3'd0;
    endcase
    return num;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcpc_channels.sv =====
// Valid/ready channel interfaces of the classifier: button events in,
// combination reports out, and the threshold register write. Uses bcpc_pkg.
`default_nettype none

interface bcpc_event_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [bcpc_pkg::BTN_IDX_W-1:0] btn_sel;
  logic [bcpc_pkg::TS_W-1:0]      timestamp_seconds;

  modport source (output valid, op, btn_sel, timestamp_seconds, input ready);
  modport sink   (input valid, op, btn_sel, timestamp_seconds, output ready);
endinterface

interface bcpc_report_if;
  logic                             valid;
  logic                             ready;
  logic [bcpc_pkg::CODE_W-1:0]      report_code;
  logic [bcpc_pkg::NUM_BUTTONS-1:0] combo_buttons;
  logic                             combo_is_long;

  modport source (output valid, report_code, combo_buttons, combo_is_long, input ready);
  modport sink   (input valid, report_code, combo_buttons, combo_is_long, output ready);
endinterface

interface bcpc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bcpc_pkg::HELD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bcpc_held_time.sv =====
// Held duration of a button in seconds, saturated to eight bits.
// Depends on bcpc_pkg for the saturation value and result width.
`default_nettype none

module bcpc_held_time #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic [TIME_WIDTH-1:0]           now_i,
  input  wire logic [TIME_WIDTH-1:0]           then_i,
  output logic      [bcpc_pkg::HELD_W-1:0]     held_o
);

  logic [TIME_WIDTH-1:0] diff;
  logic                  over;

  assign diff = now_i - then_i;

  generate
    if (TIME_WIDTH > bcpc_pkg::HELD_W) begin : g_wide
      assign over = |diff[TIME_WIDTH-1:bcpc_pkg::HELD_W];
    end else begin : g_narrow
      assign over = 1'b0;
    end
  endgenerate

  // Later release: saturated difference; earlier release: one; same time: zero.
  always_comb begin
    if (now_i > then_i) begin
      held_o = over ? bcpc_pkg::HELD_SAT : diff[bcpc_pkg::HELD_W-1:0];
    end else if (then_i > now_i) begin
      held_o = bcpc_pkg::HELD_W'(1);
    end else begin
      held_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/button_combo_press_classifier_core.sv =====
// Button combo press classifier, top level.
// Uses bcpc_pkg, the channel interfaces of bcpc_channels and bcpc_held_time.
//
// Usage:
//   evt_i  - button press/release requests: op, btn_sel, timestamp_seconds.
//   rpt_o  - one report request per event: report_code, combo_buttons and
//            combo_is_long; all zero when the event closes no combination.
//   cfg_i  - write of long_press_seconds; always ready, write only while idle.
// Path: an accepted event is held in the input register, then classified into
// the output register, where its report is valid on rpt_o until taken.
// Throughput: one event per cycle while reports are taken. The whole
// classification (held-time subtract and compare, mark update, combination
// encode) sits between the input register and the output register.
// Stall: when the report is not taken, the output register holds it and the
// input register takes one more event; further events wait on evt_i.ready.
// Reset: press times, held mask and marks clear, the threshold returns to 2
// seconds, both register stages empty.
`default_nettype none

module button_combo_press_classifier_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bcpc_event_if.sink   evt_i,
  bcpc_report_if.source rpt_o,
  bcpc_cfg_if.sink     cfg_i
);

  localparam int unsigned NB = bcpc_pkg::NUM_BUTTONS;

  // Input register stage.
  logic                           in_valid_q;
  logic                           op_q;
  logic [bcpc_pkg::BTN_IDX_W-1:0] idx_q;
  logic [bcpc_pkg::TS_W-1:0]      ts_q;

  // Output register stage.
  logic                        out_valid_q;
  logic [bcpc_pkg::CODE_W-1:0] code_q, code_d;
  logic [NB-1:0]               btn_q, btn_d;
  logic                        long_q, long_d;

  // Classifier state.
  logic [TIME_WIDTH-1:0]       press_time_q [NB];
  logic [NB-1:0]               held_q, held_d;
  logic [NB-1:0]               short_q, short_d;
  logic [NB-1:0]               longm_q, longm_d;
  logic [bcpc_pkg::HELD_W-1:0] lps_q;

  logic                        advance;
  logic                        btn_valid;
  logic [NB-1:0]               bit_mask;
  logic [TIME_WIDTH-1:0]       now;
  logic [TIME_WIDTH-1:0]       then_t;
  logic [bcpc_pkg::HELD_W-1:0] held_s;
  logic [NB-1:0]               held_after, short_mid, long_mid, combo;
  logic [bcpc_pkg::COMBO_W-1:0] combo_num;

  // Move an event into the output register whenever that register is free
  // or being drained this cycle.
  assign advance     = in_valid_q & (~out_valid_q | rpt_o.ready);
  assign evt_i.ready = ~in_valid_q | advance;
  assign cfg_i.ready = 1'b1;

  assign rpt_o.valid         = out_valid_q;
  assign rpt_o.report_code   = code_q;
  assign rpt_o.combo_buttons = btn_q;
  assign rpt_o.combo_is_long = long_q;

  // Fit the stamp to TIME_WIDTH: zero-extend it when wider, else keep only its low TIME_WIDTH bits.
  generate
    if (TIME_WIDTH > bcpc_pkg::TS_W) begin : g_ts_ext
      assign now = {{(TIME_WIDTH - bcpc_pkg::TS_W){1'b0}}, ts_q};
    end else if (TIME_WIDTH == bcpc_pkg::TS_W) begin : g_ts_eq
      assign now = ts_q;
    end else begin : g_ts_trunc
      assign now = ts_q[TIME_WIDTH-1:0];
    end
  endgenerate

  assign btn_valid = (idx_q < bcpc_pkg::NUM_BTN_IDX);
  assign bit_mask  = btn_valid ? (NB'(1) << idx_q) : '0;

  always_comb begin
    then_t = '0;
    for (int i = 0; i < NB; i++) begin
      if (bit_mask[i]) begin
        then_t = press_time_q[i];
      end
    end
  end

  bcpc_held_time #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_held_time (
    .now_i  (now),
    .then_i (then_t),
    .held_o (held_s)
  );

  // Release path: set the button's long or short mark, drop it from held.
  assign long_mid   = (held_s >= lps_q) ? (longm_q | bit_mask) : longm_q;
  assign short_mid  = (held_s >= lps_q) ? short_q : (short_q | bit_mask);
  assign held_after = held_q & ~bit_mask;
  assign combo      = (long_mid != '0) ? (long_mid | short_mid) : short_mid;
  assign combo_num  = bcpc_pkg::combo_number(combo);

  always_comb begin
    held_d  = held_q;
    short_d = short_q;
    longm_d = longm_q;
    code_d  = '0;
    btn_d   = '0;
    long_d  = 1'b0;
    if (btn_valid) begin
      if (bcpc_pkg::op_e'(op_q) == bcpc_pkg::OP_PRESS) begin
        held_d  = held_q | bit_mask;
        short_d = short_q & ~bit_mask;
        longm_d = longm_q & ~bit_mask;
      end else begin
        held_d  = held_after;
        short_d = short_mid;
        longm_d = long_mid;
        if (held_after == '0) begin
          // Last button up: report the combination and clear all marks.
          btn_d   = combo;
          short_d = '0;
          longm_d = '0;
          if (long_mid != '0) begin
            long_d = 1'b1;
            code_d = {combo_num, 1'b0} - bcpc_pkg::CODE_W'(1);
          end else if (short_mid != '0) begin
            code_d = {combo_num, 1'b0};
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      short_q     <= '0;
      longm_q     <= '0;
      lps_q       <= bcpc_pkg::LPS_RESET;
      for (int i = 0; i < NB; i++) begin
        press_time_q[i] <= '0;
      end
    end else begin
      if (evt_i.ready) begin
        in_valid_q <= evt_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        short_q     <= short_d;
        longm_q     <= longm_d;
        if (bcpc_pkg::op_e'(op_q) == bcpc_pkg::OP_PRESS) begin
          for (int i = 0; i < NB; i++) begin
            if (bit_mask[i]) begin
              press_time_q[i] <= now;
            end
          end
        end
      end else if (rpt_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        lps_q <= cfg_i.data;
      end
    end
  end

  // Payload registers: load the request and the report, no reset needed.
  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      op_q  <= evt_i.op;
      idx_q <= evt_i.btn_sel;
      ts_q  <= evt_i.timestamp_seconds;
    end
    if (advance) begin
      code_q <= code_d;
      btn_q  <= btn_d;
      long_q <= long_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/button_combo_press_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for button_combo_press_classifier_core: random and directed
// press/release requests, threshold writes between phases, reports checked in order.
// Depends on bcpc_pkg and the channel interfaces in bcpc_channels.

module button_combo_press_classifier_core_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NB          = bcpc_pkg::NUM_BUTTONS;
  localparam int unsigned IDX_W       = bcpc_pkg::BTN_IDX_W;
  localparam int unsigned TSW         = bcpc_pkg::TS_W;
  localparam int unsigned HW          = bcpc_pkg::HELD_W;

  // Combination number per button mask: A, B, M, AB, AM, BM, ABM -> 1..7.
  localparam logic [bcpc_pkg::COMBO_W-1:0] COMBO_ID [8] = '{3'd0, 3'd1, 3'd2, 3'd4,
                                                             3'd3, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    bcpc_pkg::op_e    op;
    logic [IDX_W-1:0] idx;
    logic [TSW-1:0]   ts;
  } button_event_t;

  typedef struct packed {
    logic [bcpc_pkg::CODE_W-1:0] code;
    logic [NB-1:0]               buttons;
    logic                        is_long;
  } report_t;

  logic clk_i;
  logic rst_ni;

  bcpc_event_if  evt_ch ();
  bcpc_report_if rpt_ch ();
  bcpc_cfg_if    cfg_ch ();

  button_combo_press_classifier_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt_ch),
    .rpt_o (rpt_ch),
    .cfg_i (cfg_ch)
  );

  // Requests waiting for the driver, and reports owed by the block.
  button_event_t queued_events[$];
  report_t       expected_reports[$];

  // Classifier state mirrored from the accepted requests.
  logic [TSW-1:0] press_at [NB];
  logic [NB-1:0]  held_m;
  logic [NB-1:0]  short_m;
  logic [NB-1:0]  long_m;
  logic [HW-1:0]  threshold;

  // Stall knobs, changed per phase by the sequencer.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          calm;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned errors;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Held time: forward difference saturated at the 8-bit limit, 1 when the
  // press stamp is later than the release stamp, 0 when they match.
  function automatic logic [HW-1:0] held_time(input logic [TSW-1:0] now,
                                              input logic [TSW-1:0] then_ts);
    logic [TSW-1:0] diff;
    if (now > then_ts) begin
      diff = now - then_ts;
      return (diff > TSW'(bcpc_pkg::HELD_SAT)) ? bcpc_pkg::HELD_SAT : diff[HW-1:0];
    end
    return (then_ts > now) ? HW'(1) : HW'(0);
  endfunction

  // Advance the mirrored state by one accepted request and return its report.
  function automatic report_t classify_event(input button_event_t ev);
    report_t       r;
    logic [NB-1:0] bit_m;
    logic [NB-1:0] marked;
    r = '0;
    if (ev.idx != bcpc_pkg::NUM_BTN_IDX) begin
      bit_m = NB'(1) << ev.idx;
      if (ev.op == bcpc_pkg::OP_PRESS) begin
        press_at[ev.idx] = ev.ts;
        short_m = short_m & ~bit_m;
        long_m  = long_m & ~bit_m;
        held_m  = held_m | bit_m;
      end else begin
        if (held_time(ev.ts, press_at[ev.idx]) >= threshold) long_m = long_m | bit_m;
        else short_m = short_m | bit_m;
        held_m = held_m & ~bit_m;
        // Last button up: close the combination, any long mark wins.
        if (held_m == '0) begin
          if (long_m != '0) begin
            marked    = long_m | short_m;
            r.buttons = marked;
            r.is_long = 1'b1;
            r.code    = {COMBO_ID[marked], 1'b0} - 4'd1;
          end else if (short_m != '0) begin
            r.buttons = short_m;
            r.code    = {COMBO_ID[short_m], 1'b0};
          end
          short_m = '0;
          long_m  = '0;
        end
      end
    end
    return r;
  endfunction

  // Request driver: record each accepted request in the prediction, then
  // advance to the next queued request or hold an idle burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_ch.valid             <= 1'b0;
      evt_ch.op                <= 1'b0;
      evt_ch.btn_sel           <= '0;
      evt_ch.timestamp_seconds <= '0;
      src_gap = 0;
    end else begin
      if (evt_ch.valid && evt_ch.ready) begin
        expected_reports.push_back(classify_event({bcpc_pkg::op_e'(evt_ch.op),
                                                   evt_ch.btn_sel,
                                                   evt_ch.timestamp_seconds}));
      end
      if (!evt_ch.valid || evt_ch.ready) begin
        if (src_gap != 0 && !calm) begin
          evt_ch.valid <= 1'b0;
          src_gap = src_gap - 1;
        end else if (queued_events.size() != 0) begin
          button_event_t ev;
          ev = queued_events.pop_front();
          evt_ch.valid             <= 1'b1;
          evt_ch.op                <= ev.op;
          evt_ch.btn_sel           <= ev.idx;
          evt_ch.timestamp_seconds <= ev.ts;
          src_gap = 0;
          if (!calm && $urandom_range(0, 99) < src_idle_pct) src_gap = $urandom_range(1, 9);
        end else begin
          evt_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: stall the report channel in bursts and check every taken
  // report field by field against the oldest owed one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (rpt_ch.valid && rpt_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t unexpected report: expected none, got code %0d buttons %0d long %0d",
                   $time, rpt_ch.report_code, rpt_ch.combo_buttons, rpt_ch.combo_is_long);
          errors++;
        end else begin
          report_t want;
          want = expected_reports.pop_front();
          if (rpt_ch.report_code !== want.code) begin
            $display("%0t report_code mismatch: expected %0d, actual %0d",
                     $time, want.code, rpt_ch.report_code);
            errors++;
          end
          if (rpt_ch.combo_buttons !== want.buttons) begin
            $display("%0t combo_buttons mismatch: expected %0d, actual %0d",
                     $time, want.buttons, rpt_ch.combo_buttons);
            errors++;
          end
          if (rpt_ch.combo_is_long !== want.is_long) begin
            $display("%0t combo_is_long mismatch: expected %0d, actual %0d",
                     $time, want.is_long, rpt_ch.combo_is_long);
            errors++;
          end
        end
      end
      if (snk_gap != 0 && !calm) begin
        rpt_ch.ready <= 1'b0;
        snk_gap = snk_gap - 1;
      end else begin
        rpt_ch.ready <= 1'b1;
        snk_gap = 0;
        if (!calm && $urandom_range(0, 99) < snk_idle_pct) snk_gap = $urandom_range(1, 9);
      end
    end
  end

  // Watchdog: drop the run once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_event(input bcpc_pkg::op_e op, input logic [IDX_W-1:0] idx,
                            input logic [TSW-1:0] ts);
    queued_events.push_back({op, idx, ts});
  endtask

  // Hold until no request is queued or in flight and every report has come.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_events.size() != 0 || evt_ch.valid || expected_reports.size() != 0);
  endtask

  // Write the threshold register; only called while the block is idle.
  task automatic write_threshold(input logic [HW-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    threshold = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [TSW-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1 - TSW'($urandom_range(0, 8));
      2:       return TSW'($urandom_range(0, 1000));
      default: return $urandom();
    endcase
  endfunction

  // Held durations clustered around the threshold, plus saturating and
  // backwards (press later than release) cases.
  function automatic logic [TSW-1:0] pick_hold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TSW'(threshold) - TSW'(1);
      2, 3:    return TSW'(threshold);
      4:       return TSW'(threshold) + TSW'(1);
      5:       return TSW'($urandom_range(256, 100000));
      6:       return '1 - TSW'($urandom_range(0, 300));
      7:       return $urandom();
      default: return TSW'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic queue_noise();
    push_event(bcpc_pkg::op_e'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 3)),
               $urandom());
  endtask

  // One well-formed combination: press a random set of buttons in random
  // order (now and then with a stray unknown-button request), then release them in another random order.
  task automatic queue_combo();
    logic [NB-1:0]  mask;
    logic [TSW-1:0] base;
    logic [TSW-1:0] pressed_at [NB];
    int             ord [NB];
    int             n, i, j, tmp;
    mask = NB'($urandom_range(1, 7));
    base = pick_stamp();
    n = 0;
    for (i = 0; i < NB; i++) begin
      if (mask[i]) begin
        ord[n] = i;
        n = n + 1;
      end
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
    end
    for (i = 0; i < n; i++) begin
      pressed_at[ord[i]] = base + TSW'($urandom_range(0, 3));
      push_event(bcpc_pkg::OP_PRESS, IDX_W'(ord[i]), pressed_at[ord[i]]);
      if ($urandom_range(0, 19) == 0) begin
        push_event(bcpc_pkg::op_e'($urandom_range(0, 1)), bcpc_pkg::NUM_BTN_IDX, $urandom());
      end
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
    end
    for (i = 0; i < n; i++) begin
      push_event(bcpc_pkg::OP_RELEASE, IDX_W'(ord[i]), pressed_at[ord[i]] + pick_hold());
    end
  endtask

  // Fill one phase: mostly combinations, the rest stray requests; optionally
  // hold the sender halfway until every report has arrived.
  task automatic run_phase(input int unsigned n_items, input bit drain_midway);
    int unsigned goal;
    goal = queued_events.size() + n_items / 2;
    while (queued_events.size() < goal) begin
      if ($urandom_range(0, 99) < 80) queue_combo();
      else repeat ($urandom_range(1, 4)) queue_noise();
    end
    if (drain_midway) wait_drained();
    goal = queued_events.size() + n_items - n_items / 2;
    while (queued_events.size() < goal) begin
      if ($urandom_range(0, 99) < 80) queue_combo();
      else repeat ($urandom_range(1, 4)) queue_noise();
    end
    wait_drained();
  endtask

  task automatic set_stalls();
    int unsigned levels [4] = '{0, 10, 30, 60};
    src_idle_pct = levels[$urandom_range(0, 3)];
    snk_idle_pct = levels[$urandom_range(0, 3)];
  endtask

  // Sequencer: reset, directed cases at the reset threshold, then random
  // phases under several thresholds, the last one without stalls.
  initial begin
    for (int b = 0; b < NB; b++) press_at[b] = '0;
    held_m       = '0;
    short_m      = '0;
    long_m       = '0;
    threshold    = bcpc_pkg::LPS_RESET;
    calm         = 1'b0;
    errors       = 0;
    cycles       = 0;
    src_idle_pct = 20;
    snk_idle_pct = 20;
    rst_ni       <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unknown button index, both kinds, extreme stamps.
    push_event(bcpc_pkg::OP_PRESS,   bcpc_pkg::NUM_BTN_IDX, '1);
    push_event(bcpc_pkg::OP_RELEASE, bcpc_pkg::NUM_BTN_IDX, '0);
    // Release of a never-pressed button: press stamp is still zero.
    push_event(bcpc_pkg::OP_RELEASE, 2'd1, 32'd1);
    // Equal stamps give zero held time.
    push_event(bcpc_pkg::OP_PRESS,   2'd0, 32'd100);
    push_event(bcpc_pkg::OP_RELEASE, 2'd0, 32'd100);
    // Press later than release counts as one second.
    push_event(bcpc_pkg::OP_PRESS,   2'd1, 32'd200);
    push_event(bcpc_pkg::OP_RELEASE, 2'd1, 32'd150);
    // Full span saturates the held time.
    push_event(bcpc_pkg::OP_PRESS,   2'd2, '0);
    push_event(bcpc_pkg::OP_RELEASE, 2'd2, '1);
    // Release of a button not held reuses its old press stamp.
    push_event(bcpc_pkg::OP_RELEASE, 2'd0, 32'd102);
    // Three-button combination with one long mark makes the whole set long.
    push_event(bcpc_pkg::OP_PRESS,   2'd0, 32'h8000_0000);
    push_event(bcpc_pkg::OP_PRESS,   2'd1, 32'h8000_0000);
    push_event(bcpc_pkg::OP_PRESS,   2'd2, 32'h8000_0001);
    push_event(bcpc_pkg::OP_RELEASE, 2'd1, 32'h8000_0003);
    push_event(bcpc_pkg::OP_RELEASE, bcpc_pkg::NUM_BTN_IDX, 32'h5555_5555);
    push_event(bcpc_pkg::OP_RELEASE, 2'd0, 32'h8000_0001);
    push_event(bcpc_pkg::OP_RELEASE, 2'd2, 32'h8000_0002);
    // Re-press clears a pending mark; the pair still closes as long through button 1.
    push_event(bcpc_pkg::OP_PRESS,   2'd0, 32'h0000_ffff);
    push_event(bcpc_pkg::OP_PRESS,   2'd1, 32'h0000_ffff);
    push_event(bcpc_pkg::OP_RELEASE, 2'd0, 32'h0001_0003);
    push_event(bcpc_pkg::OP_PRESS,   2'd0, 32'h0001_0004);
    push_event(bcpc_pkg::OP_RELEASE, 2'd1, 32'h0001_0004);
    push_event(bcpc_pkg::OP_RELEASE, 2'd0, 32'h0001_0005);
    wait_drained();

    set_stalls();
    write_threshold(8'd0);
    run_phase(150, 1'b1);
    set_stalls();
    write_threshold(8'd255);
    run_phase(150, 1'b0);
    set_stalls();
    write_threshold(8'd1);
    run_phase(150, 1'b0);
    set_stalls();
    write_threshold(HW'($urandom_range(3, 254)));
    run_phase(150, 1'b1);
    set_stalls();
    write_threshold(HW'($urandom()));
    run_phase(150, 1'b0);

    // Last part: no idling on either side.
    calm = 1'b1;
    write_threshold(bcpc_pkg::LPS_RESET);
    run_phase(150, 1'b0);

    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
